@@ src/avm_pkg.sv @@
// Shared types, constants and codes of the ADSR envelope voice manager.
package avm_pkg;

  localparam int VOICES_DEF = 8;
  localparam int KIND_W     = 2;
  localparam int NOTE_W     = 7;
  localparam int VEL_W      = 8;
  localparam int LEVEL_W    = 25;
  localparam int IDX_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  localparam logic [LEVEL_W-1:0] ONE_Q24   = 25'd16777216;
  localparam logic [NOTE_W-1:0]  NOTE_LOW  = 7'd24;
  localparam logic [NOTE_W-1:0]  NOTE_HIGH = 7'd96;
  localparam logic [VEL_W-1:0]   VEL_MIN   = 8'd13;

  localparam logic [LEVEL_W-1:0] ATTACK_RESET  = 25'd58254;
  localparam logic [LEVEL_W-1:0] DECAY_RESET   = 25'd604;
  localparam logic [LEVEL_W-1:0] SUSTAIN_RESET = 25'd10401874;
  localparam logic [LEVEL_W-1:0] RELEASE_RESET = 25'd1248;

  typedef enum logic [KIND_W-1:0] {
    KIND_NOTE_ON  = 2'd0,
    KIND_NOTE_OFF = 2'd1,
    KIND_TICK     = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    STAGE_IDLE    = 3'd0,
    STAGE_ATTACK  = 3'd1,
    STAGE_DECAY   = 3'd2,
    STAGE_SUSTAIN = 3'd3,
    STAGE_RELEASE = 3'd4
  } stage_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK_STEP   = 3'd0,
    REG_DECAY_STEP    = 3'd1,
    REG_SUSTAIN_LEVEL = 3'd2,
    REG_RELEASE_STEP  = 3'd3,
    REG_MONO_MODE     = 3'd4,
    REG_LEGATO_ENABLE = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_OFF,
    S_TICK
  } state_t;

  typedef struct packed {
    logic latch;
    logic alloc;
    logic note_off;
    logic tick_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic idx_last;
  } status_t;

endpackage

@@ src/avm_item_if.sv @@
// Input item channel: kind, note and velocity with valid and ready.
interface avm_item_if;
  logic                        valid;
  logic                        ready;
  logic [avm_pkg::KIND_W-1:0]  kind;
  logic [avm_pkg::NOTE_W-1:0]  note;
  logic [avm_pkg::VEL_W-1:0]   velocity;

  modport source (output valid, kind, note, velocity, input ready);
  modport sink (input valid, kind, note, velocity, output ready);
endinterface

@@ src/avm_result_if.sv @@
// Result channel: one voice report per transfer with valid and ready.
interface avm_result_if;
  logic                         valid;
  logic                         ready;
  logic [avm_pkg::IDX_W-1:0]    voice_index;
  logic                         voice_active;
  logic [avm_pkg::NOTE_W-1:0]   voice_note;
  logic [avm_pkg::VEL_W-1:0]    voice_velocity;
  logic [avm_pkg::LEVEL_W-1:0]  env_level;
  logic [2:0]                   env_stage;
  logic                         last;

  modport source (output valid, voice_index, voice_active, voice_note, voice_velocity,
                  env_level, env_stage, last, input ready);
  modport sink (input valid, voice_index, voice_active, voice_note, voice_velocity,
                env_level, env_stage, last, output ready);
endinterface

@@ src/avm_cfg_if.sv @@
// Configuration write channel: register index and data with valid and ready.
interface avm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [avm_pkg::CFG_IDX_W-1:0]   index;
  logic [avm_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/avm_ctrl.sv @@
// Controller state machine that sequences note events and voice reports.
module avm_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [avm_pkg::KIND_W-1:0]  in_kind,
  input  avm_pkg::status_t            status,
  output logic                        in_ready,
  output avm_pkg::cmd_t               cmd
);

  avm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= avm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      avm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          unique case (avm_pkg::kind_t'(in_kind))
            avm_pkg::KIND_NOTE_ON:  state_next = avm_pkg::S_ALLOC;
            avm_pkg::KIND_NOTE_OFF: state_next = avm_pkg::S_OFF;
            avm_pkg::KIND_TICK:     state_next = avm_pkg::S_TICK;
            default:                state_next = avm_pkg::S_IDLE;
          endcase
        end
      end
      avm_pkg::S_ALLOC: begin
        if (status.out_free) begin
          cmd.alloc  = 1'b1;
          state_next = avm_pkg::S_IDLE;
        end
      end
      avm_pkg::S_OFF: begin
        cmd.note_off = 1'b1;
        state_next   = avm_pkg::S_IDLE;
      end
      avm_pkg::S_TICK: begin
        if (status.out_free) begin
          cmd.tick_load = 1'b1;
          if (status.idx_last) begin
            state_next = avm_pkg::S_IDLE;
          end
        end
      end
      default: state_next = avm_pkg::S_IDLE;
    endcase
  end

endmodule

@@ src/avm_datapath.sv @@
// Datapath: configuration, voice state, allocation, envelope step and result register.
module avm_datapath #(
  parameter int VOICES = avm_pkg::VOICES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  avm_pkg::cmd_t                   cmd,
  output avm_pkg::status_t                status,
  input  logic [avm_pkg::NOTE_W-1:0]      in_note,
  input  logic [avm_pkg::VEL_W-1:0]       in_velocity,
  input  logic                            cfg_wr,
  input  logic [avm_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [avm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [avm_pkg::IDX_W-1:0]       out_index,
  output logic                            out_active,
  output logic [avm_pkg::NOTE_W-1:0]      out_note,
  output logic [avm_pkg::VEL_W-1:0]       out_velocity,
  output logic [avm_pkg::LEVEL_W-1:0]     out_level,
  output logic [2:0]                      out_stage,
  output logic                            out_last
);

  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int IW     = avm_pkg::IDX_W;
  localparam int LW     = avm_pkg::LEVEL_W;

  logic [LW-1:0] attack_step, decay_step, sustain_level, release_step;
  logic          mono_mode, legato_enable;

  logic [avm_pkg::NOTE_W-1:0] lat_note;
  logic [avm_pkg::VEL_W-1:0]  lat_vel;
  logic [VIDX_W-1:0]          idx;

  logic [VOICES-1:0]          active_flags;
  logic [avm_pkg::NOTE_W-1:0] note_store [VOICES];
  logic [avm_pkg::VEL_W-1:0]  velocity_store [VOICES];
  logic [LW-1:0]              level_store [VOICES];
  avm_pkg::stage_t            stage_store [VOICES];

  logic [avm_pkg::NOTE_W-1:0] note_clamp;
  logic [avm_pkg::VEL_W-1:0]  vel_clamp;
  logic [VIDX_W-1:0]          pick;
  logic                       legato;
  logic [LW-1:0]              alloc_level;
  logic [VOICES-1:0]          rel_mask;
  logic [LW-1:0]              sus_sat;

  logic [LW-1:0]              cur_lvl;
  avm_pkg::stage_t            cur_stage;
  logic                       cur_act;
  logic [LW:0]                att_sum;
  logic signed [LW+1:0]       dec_diff, rel_diff;
  logic [LW-1:0]              step_lvl;
  avm_pkg::stage_t            step_stage;
  logic                       step_act;

  assign status.out_free = !out_valid || out_ready;
  assign status.idx_last = (idx == VIDX_W'(VOICES - 1));

  assign note_clamp = (lat_note < avm_pkg::NOTE_LOW) ? avm_pkg::NOTE_LOW :
                      (lat_note > avm_pkg::NOTE_HIGH) ? avm_pkg::NOTE_HIGH : lat_note;
  assign vel_clamp  = (lat_vel < avm_pkg::VEL_MIN) ? avm_pkg::VEL_MIN : lat_vel;
  assign legato     = mono_mode && active_flags[0] && legato_enable;
  assign alloc_level = legato ? level_store[pick] : '0;
  assign sus_sat    = (sustain_level > avm_pkg::ONE_Q24) ? avm_pkg::ONE_Q24 : sustain_level;

  always_comb begin
    pick = '0;
    for (int v = VOICES - 1; v >= 0; v--) begin
      if (!active_flags[v]) begin
        pick = VIDX_W'(v);
      end
    end
    if (mono_mode) begin
      pick = '0;
    end
  end

  always_comb begin : release_sel
    logic found;
    found    = 1'b0;
    rel_mask = '0;
    for (int v = 0; v < VOICES; v++) begin
      if (active_flags[v] && (note_store[v] == lat_note) && !(mono_mode && found)) begin
        rel_mask[v] = 1'b1;
        found       = 1'b1;
      end
    end
  end

  assign cur_lvl   = level_store[idx];
  assign cur_stage = stage_store[idx];
  assign cur_act   = active_flags[idx];
  assign att_sum   = {1'b0, cur_lvl} + {1'b0, attack_step};
  assign dec_diff  = $signed({2'b00, cur_lvl}) - $signed({2'b00, decay_step});
  assign rel_diff  = $signed({2'b00, cur_lvl}) - $signed({2'b00, release_step});

  always_comb begin
    step_lvl   = cur_lvl;
    step_stage = cur_stage;
    step_act   = cur_act;
    if (cur_act) begin
      unique case (cur_stage)
        avm_pkg::STAGE_ATTACK: begin
          if (att_sum >= {1'b0, avm_pkg::ONE_Q24}) begin
            step_lvl   = avm_pkg::ONE_Q24;
            step_stage = avm_pkg::STAGE_DECAY;
          end else begin
            step_lvl = att_sum[LW-1:0];
          end
        end
        avm_pkg::STAGE_DECAY: begin
          if (dec_diff <= $signed({2'b00, sus_sat})) begin
            step_lvl   = sus_sat;
            step_stage = avm_pkg::STAGE_SUSTAIN;
          end else begin
            step_lvl = dec_diff[LW-1:0];
          end
        end
        avm_pkg::STAGE_SUSTAIN: step_lvl = sus_sat;
        avm_pkg::STAGE_RELEASE: begin
          if (rel_diff <= $signed((LW+2)'(0))) begin
            step_lvl   = '0;
            step_stage = avm_pkg::STAGE_IDLE;
            step_act   = 1'b0;
          end else begin
            step_lvl = rel_diff[LW-1:0];
          end
        end
        default: step_lvl = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_step   <= avm_pkg::ATTACK_RESET;
      decay_step    <= avm_pkg::DECAY_RESET;
      sustain_level <= avm_pkg::SUSTAIN_RESET;
      release_step  <= avm_pkg::RELEASE_RESET;
      mono_mode     <= 1'b0;
      legato_enable <= 1'b0;
      active_flags  <= '0;
      out_valid     <= 1'b0;
      idx           <= '0;
      for (int v = 0; v < VOICES; v++) begin
        note_store[v]     <= '0;
        velocity_store[v] <= '0;
        level_store[v]    <= '0;
        stage_store[v]    <= avm_pkg::STAGE_IDLE;
      end
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          avm_pkg::REG_ATTACK_STEP:   attack_step   <= cfg_data;
          avm_pkg::REG_DECAY_STEP:    decay_step    <= cfg_data;
          avm_pkg::REG_SUSTAIN_LEVEL: sustain_level <= cfg_data;
          avm_pkg::REG_RELEASE_STEP:  release_step  <= cfg_data;
          avm_pkg::REG_MONO_MODE:     mono_mode     <= cfg_data[0];
          avm_pkg::REG_LEGATO_ENABLE: legato_enable <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.latch) begin
        idx <= '0;
      end
      if (cmd.alloc) begin
        active_flags[pick]   <= 1'b1;
        note_store[pick]     <= note_clamp;
        velocity_store[pick] <= vel_clamp;
        level_store[pick]    <= alloc_level;
        stage_store[pick]    <= avm_pkg::STAGE_ATTACK;
      end
      if (cmd.note_off) begin
        for (int v = 0; v < VOICES; v++) begin
          if (rel_mask[v]) begin
            stage_store[v] <= avm_pkg::STAGE_RELEASE;
          end
        end
      end
      if (cmd.tick_load) begin
        active_flags[idx] <= step_act;
        level_store[idx]  <= step_lvl;
        stage_store[idx]  <= step_stage;
        idx               <= idx + VIDX_W'(1);
      end
      if (cmd.alloc || cmd.tick_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lat_note <= in_note;
      lat_vel  <= in_velocity;
    end
    if (cmd.alloc) begin
      out_index    <= IW'(pick);
      out_active   <= 1'b1;
      out_note     <= note_clamp;
      out_velocity <= vel_clamp;
      out_level    <= alloc_level;
      out_stage    <= avm_pkg::STAGE_ATTACK;
      out_last     <= 1'b1;
    end else if (cmd.tick_load) begin
      out_index    <= IW'(idx);
      out_active   <= step_act;
      out_note     <= note_store[idx];
      out_velocity <= velocity_store[idx];
      out_level    <= step_lvl;
      out_stage    <= step_stage;
      out_last     <= status.idx_last;
    end
  end

endmodule

@@ src/adsr_envelope_voice_manager.sv @@
// Top level of the polyphonic voice manager with linear ADSR envelopes.
//
//   channel   modport   transfer carries
//   items     sink      kind, note, velocity
//   results   source    voice_index, voice_active, voice_note, voice_velocity,
//                       env_level, env_stage, last
//   cfg       sink      index, data (always ready)
//
// One item is worked on at a time; ready is high only while the controller is idle.
// After the transfer a tick steps every voice in turn, one voice per cycle while the result register is free.
// A note-on passes through the alloc state and a note-off through the off state; an unused kind returns to idle.
// The single result register sets the pace: a voice is stepped only when it is free.
// Reset is synchronous and clears all voices and restores the register defaults.
module adsr_envelope_voice_manager #(
  parameter int VOICES = avm_pkg::VOICES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  avm_item_if.sink      items,
  avm_result_if.source  results,
  avm_cfg_if.sink       cfg
);

  avm_pkg::cmd_t    cmd;
  avm_pkg::status_t status;
  logic [2:0]       stage_bits;

  assign cfg.ready = 1'b1;
  assign results.env_stage = stage_bits;

  avm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_kind  (items.kind),
    .status   (status),
    .in_ready (items.ready),
    .cmd      (cmd)
  );

  avm_datapath #(
    .VOICES (VOICES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_note      (items.note),
    .in_velocity  (items.velocity),
    .cfg_wr       (cfg.valid),
    .cfg_idx      (cfg.index),
    .cfg_data     (cfg.data),
    .out_ready    (results.ready),
    .out_valid    (results.valid),
    .out_index    (results.voice_index),
    .out_active   (results.voice_active),
    .out_note     (results.voice_note),
    .out_velocity (results.voice_velocity),
    .out_level    (results.env_level),
    .out_stage    (stage_bits),
    .out_last     (results.last)
  );

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready && (items.kind == avm_pkg::KIND_TICK)) |=> !items.ready)
    else $error("Block took a new item right after a tick transfer.");

  a_active_stage: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.voice_active == (results.env_stage != avm_pkg::STAGE_IDLE)))
    else $error("Reported voice activity disagrees with its envelope stage.");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.env_level <= avm_pkg::ONE_Q24))
    else $error("Reported envelope level is above full scale.");

endmodule
